@@ rtl/core/dmdr_pkg.sv @@
// Shared types and constants for the DoP marker decoder.
// Used by the front, queue, back, top level and checker; no dependencies.
`default_nettype none

package dmdr_pkg;

  localparam int unsigned MaxChannelsDefault = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CountW   = 16;

  // Output tdata bit positions
  localparam int unsigned OutEarlyLsb = 0;
  localparam int unsigned OutLateLsb  = 8;
  localparam int unsigned OutChanLsb  = 16;
  localparam int unsigned OutGoodBit  = 19;
  localparam int unsigned OutLockBit  = 20;
  localparam int unsigned OutCountLsb = 21;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChannelCount = 2'd0,
    CfgMarkerEven   = 2'd1,
    CfgMarkerOdd    = 2'd2
  } cfg_reg_e;

  // Word classified by the front, consumed by the back
  typedef struct packed {
    logic [7:0] dsd_early;
    logic [7:0] dsd_late;
    logic [2:0] channel_index;
    logic       frame_start;
    logic       marker_ok;
    logic       end_of_block;
  } item_t;

  // Result word held in the back output register
  typedef struct packed {
    logic [7:0]        dsd_early;
    logic [7:0]        dsd_late;
    logic [2:0]        channel_index;
    logic              frame_good;
    logic              lock_state;
    logic [CountW-1:0] good_frames;
    logic              block_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/dmdr_front.sv @@
// Front end: configuration registers, frame position tracking and marker check.
// Depends on dmdr_pkg.
`default_nettype none

module dmdr_front #(
  parameter int unsigned MaxChannels = dmdr_pkg::MaxChannelsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dmdr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dmdr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dmdr_pkg::InDataW-1:0]  in_sample_i,
  input  wire logic                          in_last_i,
  output logic                               push_o,
  output dmdr_pkg::item_t                    item_o,
  input  wire logic                          full_i
);

  localparam int unsigned PosW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned CmpW = (PosW + 1 > 4) ? PosW + 1 : 4;

  logic [3:0]      chan_count_q;
  logic [7:0]      marker_even_q;
  logic [7:0]      marker_odd_q;
  logic            parity_q, parity_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic [CmpW-1:0] nch;
  logic [CmpW-1:0] cc_ext;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] pos_inc;
  logic [7:0]      got;
  logic [7:0]      want;
  logic [7:0]      alt;
  logic            accept;
  logic            start;
  logic            ok;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~full_i;
  assign accept      = in_valid_i & ~full_i;
  assign push_o      = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q  <= 4'd2;
      marker_even_q <= 8'd5;
      marker_odd_q  <= 8'd250;
    end else if (cfg_valid_i) begin
      case (dmdr_pkg::cfg_reg_e'(cfg_index_i))
        dmdr_pkg::CfgChannelCount: chan_count_q  <= cfg_data_i[3:0];
        dmdr_pkg::CfgMarkerEven:   marker_even_q <= cfg_data_i;
        dmdr_pkg::CfgMarkerOdd:    marker_odd_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cc_ext = CmpW'(chan_count_q);
    if (cc_ext == '0) begin
      nch = CmpW'(1);
    end else if (cc_ext > CmpW'(MaxChannels)) begin
      nch = CmpW'(MaxChannels);
    end else begin
      nch = cc_ext;
    end
    // a stale position past a reduced channel count restarts the frame
    pos_ext = (CmpW'(pos_q) >= nch) ? '0 : CmpW'(pos_q);
    pos_inc = pos_ext + CmpW'(1);
    start   = (pos_ext == '0);

    got  = in_sample_i[23:16];
    want = parity_q ? marker_odd_q : marker_even_q;
    alt  = parity_q ? marker_even_q : marker_odd_q;
    ok   = (got == want) | (got == alt);

    parity_d = parity_q;
    if (start && got != alt) begin
      parity_d = ~parity_q;
    end
    if (start && got == want) begin
      parity_d = ~parity_q;
    end

    if (in_last_i || pos_inc >= nch) begin
      pos_d = '0;
    end else begin
      pos_d = PosW'(pos_inc);
    end

    item_o.dsd_early     = in_sample_i[15:8];
    item_o.dsd_late      = in_sample_i[7:0];
    item_o.channel_index = pos_ext[2:0];
    item_o.frame_start   = start;
    item_o.marker_ok     = ok;
    item_o.end_of_block  = in_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      pos_q    <= '0;
    end else if (accept) begin
      parity_q <= parity_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dmdr_queue.sv @@
// Two-entry queue between front and back halves.
// Depends on dmdr_pkg.
`default_nettype none

module dmdr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dmdr_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output dmdr_pkg::item_t      item_o,
  output logic                 empty_o
);

  dmdr_pkg::item_t mem_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dmdr_back.sv @@
// Back end: frame status, lock flag, per-block good-frame count, output register.
// Depends on dmdr_pkg.
`default_nettype none

module dmdr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dmdr_pkg::item_t item_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dmdr_pkg::result_t    result_o
);

  logic                        frame_good_q, frame_good_d;
  logic                        lock_q, lock_d;
  logic [dmdr_pkg::CountW-1:0] count_q, count_d, count_out;
  logic                        valid_q;
  dmdr_pkg::result_t           result_q, result_d;

  // advance when the output register is free or being drained
  assign pop_o       = ~empty_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_comb begin
    frame_good_d = frame_good_q;
    lock_d       = lock_q;
    count_out    = count_q;
    if (item_i.frame_start) begin
      frame_good_d = item_i.marker_ok;
      if (item_i.marker_ok) begin
        lock_d = 1'b1;
        if (count_q != '1) begin
          count_out = count_q + dmdr_pkg::CountW'(1);
        end
      end
    end
    count_d = item_i.end_of_block ? '0 : count_out;

    result_d.dsd_early     = item_i.dsd_early;
    result_d.dsd_late      = item_i.dsd_late;
    result_d.channel_index = item_i.channel_index;
    result_d.frame_good    = frame_good_d;
    result_d.lock_state    = lock_d;
    result_d.good_frames   = count_out;
    result_d.block_done    = item_i.end_of_block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_good_q <= 1'b0;
      lock_q       <= 1'b0;
      count_q      <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        frame_good_q <= frame_good_d;
        lock_q       <= lock_d;
        count_q      <= count_d;
        valid_q      <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dop_marker_decoder_resync.sv @@
// DoP marker decoder with one-frame resync: top level.
// Path: an accepted input word is written into the queue, then into the output register.
// Throughput: one word per cycle while the output is not stalled; a two-entry queue plus the
// output register absorb a stalled output for two more words before s_axis_tready drops.
// Reset (rst_ni, async, active low): queue empty, parity even, lock and count
// clear, channel_count 2, markers 0x05 / 0xFA.
// Depends on dmdr_pkg, dmdr_front, dmdr_queue, dmdr_back.
`default_nettype none

module dop_marker_decoder_resync #(
  parameter int unsigned MaxChannels = dmdr_pkg::MaxChannelsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dmdr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dmdr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] l24_sample
  input  wire logic [dmdr_pkg::InDataW-1:0]   s_axis_tdata,
  // end_of_block
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] dsd_early, [15:8] dsd_late, [18:16] channel_index, [19] frame_good,
  // [20] lock_state, [36:21] good_frames, [39:37] zero
  output logic [dmdr_pkg::OutDataW-1:0]       m_axis_tdata,
  // block_done
  output logic                                m_axis_tlast
);

  dmdr_pkg::item_t   front_item;
  dmdr_pkg::item_t   queue_item;
  dmdr_pkg::result_t result;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  dmdr_front #(
    .MaxChannels(MaxChannels)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .item_o      (front_item),
    .full_i      (full)
  );

  dmdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  dmdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (queue_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {3'b000, result.good_frames, result.lock_state, result.frame_good,
                         result.channel_index, result.dsd_late, result.dsd_early};
  assign m_axis_tlast = result.block_done;

endmodule

`default_nettype wire

@@ rtl/core/dmdr_checker.sv @@
// Port-level checker for the DoP marker decoder, bound to the top level.
// Depends on dmdr_pkg and dop_marker_decoder_resync.
`default_nettype none

module dmdr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dmdr_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  logic                        out_acc;
  logic                        lock_seen_q;
  logic                        after_eob_q;
  logic [dmdr_pkg::CountW-1:0] count_now;
  logic                        lock_now;

  assign out_acc   = m_axis_tvalid & m_axis_tready;
  assign count_now = m_axis_tdata[dmdr_pkg::OutCountLsb +: dmdr_pkg::CountW];
  assign lock_now  = m_axis_tdata[dmdr_pkg::OutLockBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_seen_q <= 1'b0;
      after_eob_q <= 1'b0;
    end else if (out_acc) begin
      lock_seen_q <= lock_seen_q | lock_now;
      after_eob_q <= m_axis_tlast;
    end
  end

  // hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // lock never drops once reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && lock_seen_q |-> lock_now)
    else $error("lock flag dropped");

  // count restarts after the end of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && after_eob_q |-> count_now <= dmdr_pkg::CountW'(1))
    else $error("good-frame count not cleared after block end");

  // any counted frame implies lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_now != '0 |-> lock_now)
    else $error("good frames counted without lock");

endmodule

bind dop_marker_decoder_resync dmdr_checker u_dmdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ verif/dmdr_result_checker.sv @@
// Result checker for the DoP marker decoder: watches the config, input and output channels.
// Predicts each output word from its own decoder state and compares it field by field.
// Depends on dmdr_pkg.
`timescale 1ns / 1ps

module dmdr_result_checker
  import dmdr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_tready_i,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic                s_tlast_i,
  input  wire logic                m_tvalid_i,
  input  wire logic                m_tready_i,
  input  wire logic [OutDataW-1:0] m_tdata_i,
  input  wire logic                m_tlast_i,
  output int                       errors_o,
  output int                       pending_o
);

  localparam logic [3:0] MaxCh = 4'(MaxChannelsDefault);

  logic [3:0]        chan_cnt_q;
  logic [7:0]        mark_even_q;
  logic [7:0]        mark_odd_q;
  logic              parity_q;
  logic              locked_q;
  logic              frame_ok_q;
  logic [3:0]        chan_pos_q;
  logic [CountW-1:0] good_cnt_q;

  result_t pending_results[$];
  int      err_cnt = 0;
  int      depth = 0;

  assign errors_o  = err_cnt;
  assign pending_o = depth;

  task automatic decode_word(input logic [InDataW-1:0] sample, input logic eob,
                             output result_t res);
    logic [3:0] nch;
    logic [3:0] pos;
    logic [7:0] got;
    logic [7:0] want;
    logic [7:0] alt;
    nch = chan_cnt_q;
    if (nch == 4'd0) nch = 4'd1;
    if (nch > MaxCh) nch = MaxCh;
    // a shrunk channel count can leave the position past the frame end
    if (chan_pos_q >= nch) chan_pos_q = 4'd0;
    pos = chan_pos_q;
    if (pos == 4'd0) begin
      got  = sample[23:16];
      want = parity_q ? mark_odd_q : mark_even_q;
      alt  = parity_q ? mark_even_q : mark_odd_q;
      if (got == want) begin
        frame_ok_q = 1'b1;
        parity_q   = ~parity_q;
      end else if (got == alt) begin
        // slip: keep parity so the same marker is expected next frame
        frame_ok_q = 1'b1;
      end else begin
        frame_ok_q = 1'b0;
        parity_q   = ~parity_q;
      end
      if (frame_ok_q) begin
        locked_q = 1'b1;
        if (good_cnt_q != '1) good_cnt_q = good_cnt_q + CountW'(1);
      end
    end
    res.dsd_early     = sample[15:8];
    res.dsd_late      = sample[7:0];
    res.channel_index = pos[2:0];
    res.frame_good    = frame_ok_q;
    res.lock_state    = locked_q;
    res.good_frames   = good_cnt_q;
    res.block_done    = eob;
    if (eob) begin
      good_cnt_q = '0;
      chan_pos_q = 4'd0;
    end else begin
      chan_pos_q = pos + 4'd1;
      if (chan_pos_q >= nch) chan_pos_q = 4'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t predicted;
    result_t want;
    if (!rst_ni) begin
      chan_cnt_q  = 4'd2;
      mark_even_q = 8'h05;
      mark_odd_q  = 8'hFA;
      parity_q    = 1'b0;
      locked_q    = 1'b0;
      frame_ok_q  = 1'b0;
      chan_pos_q  = 4'd0;
      good_cnt_q  = '0;
      pending_results.delete();
      depth = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgChannelCount: chan_cnt_q  = cfg_data_i[3:0];
          CfgMarkerEven:   mark_even_q = cfg_data_i;
          CfgMarkerOdd:    mark_odd_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_word(s_tdata_i, s_tlast_i, predicted);
        pending_results.push_back(predicted);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected output word, expected none, actual %h last %b",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          want = pending_results.pop_front();
          check_field("dsd_early", 16'(want.dsd_early), 16'(m_tdata_i[OutEarlyLsb +: 8]));
          check_field("dsd_late", 16'(want.dsd_late), 16'(m_tdata_i[OutLateLsb +: 8]));
          check_field("channel_index", 16'(want.channel_index),
                      16'(m_tdata_i[OutChanLsb +: 3]));
          check_field("frame_good", 16'(want.frame_good), 16'(m_tdata_i[OutGoodBit]));
          check_field("lock_state", 16'(want.lock_state), 16'(m_tdata_i[OutLockBit]));
          check_field("good_frames", want.good_frames, m_tdata_i[OutCountLsb +: CountW]);
          check_field("pad", 16'd0, 16'(m_tdata_i[OutDataW-1:OutCountLsb+CountW]));
          check_field("block_done", 16'(want.block_done), 16'(m_tlast_i));
        end
      end
      depth = pending_results.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the DoP marker decoder: clock, reset, config writes and stream stimulus.
// Checking is done by dmdr_result_checker; depends on dmdr_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import dmdr_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int RxHoldCycles = 80;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int errors;
  int outstanding;
  int tx_idle_pct = 33;
  int rx_idle_pct = 46;
  bit rx_hold_req = 1'b0;

  // stimulus-side copies of what was last written, used to pick markers
  logic [3:0] tb_chan_cnt = 4'd2;
  logic [7:0] tb_mark_even = 8'h05;
  logic [7:0] tb_mark_odd = 8'hFA;
  bit         mark_parity = 1'b0;

  dop_marker_decoder_resync uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  dmdr_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .errors_o    (errors),
    .pending_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Idle steps are drawn one by one so the idle share of cycles matches tx_idle_pct
  task automatic send_word(input logic [InDataW-1:0] sample, input logic eob);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sample the checker's queue depth away from the active edge
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Frame position is not cleared here, so a new count can land mid-frame
  task automatic apply_config(input logic [3:0] chans, input logic [7:0] even,
                              input logic [7:0] odd, input bit poke_unused);
    drain_results();
    write_reg(CfgChannelCount, {4'($urandom_range(15)), chans});
    write_reg(CfgMarkerEven, even);
    write_reg(CfgMarkerOdd, odd);
    if (poke_unused) write_reg(CfgUnused, 8'($urandom_range(255)));
    cfg_valid    <= 1'b0;
    tb_chan_cnt  = chans;
    tb_mark_even = even;
    tb_mark_odd  = odd;
  endtask

  // Mostly well-formed alternating frames; some slips, bad markers and early block ends
  task automatic send_frames(input int n_items);
    int          sent;
    int          nch;
    int          pick;
    logic [23:0] sample;
    logic        eob;
    sent = 0;
    while (sent < n_items) begin
      nch = (tb_chan_cnt == 0) ? 1 : ((tb_chan_cnt > 8) ? 8 : int'(tb_chan_cnt));
      for (int k = 0; k < nch && sent < n_items; k++) begin
        sample = 24'($urandom);
        if (k == 0) begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            sample[23:16] = mark_parity ? tb_mark_odd : tb_mark_even;
            mark_parity = ~mark_parity;
          end else if (pick < 87) begin
            sample[23:16] = mark_parity ? tb_mark_even : tb_mark_odd;
          end else begin
            mark_parity = ~mark_parity;
          end
        end
        eob = ($urandom_range(99) < 4);
        send_word(sample, eob);
        sent++;
        if (eob) break;
      end
    end
  endtask

  initial begin
    logic [7:0] mk;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default two channels, markers 05 / FA
    send_word(24'h0500FF, 1'b0);
    send_word(24'hFFFFFF, 1'b0);
    send_word(24'hFAFF00, 1'b0);
    send_word(24'h000000, 1'b0);
    send_word(24'hFAA55A, 1'b0);   // opposite marker: slip
    send_word(24'h5A5A5A, 1'b0);
    send_word(24'h051234, 1'b1);   // block ends mid-frame
    send_word(24'h770000, 1'b0);   // unknown marker: bad frame
    send_word(24'h123456, 1'b1);
    send_word(24'hFAFFFF, 1'b0);

    // Zero channel count acts as one
    apply_config(4'd0, 8'h05, 8'hFA, 1'b0);
    send_word(24'h050102, 1'b0);
    send_word(24'hFA0304, 1'b0);
    send_word(24'h050506, 1'b0);

    // Count above the maximum acts as the maximum; extreme markers
    apply_config(4'd15, 8'h00, 8'hFF, 1'b0);
    send_word(24'h00ABCD, 1'b0);
    send_word(24'h111111, 1'b0);
    send_word(24'h222222, 1'b0);
    send_word(24'h333333, 1'b0);
    send_word(24'h444444, 1'b0);
    send_word(24'h555555, 1'b0);

    // Shrink the count mid-frame and use equal markers
    apply_config(4'd3, 8'h3C, 8'h3C, 1'b1);
    send_word(24'h3C0F0F, 1'b0);
    send_word(24'hC3F0F0, 1'b0);
    send_word(24'h999999, 1'b0);
    send_word(24'h3C8001, 1'b1);

    // Run of good single-channel frames back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(4'd1, 8'h05, 8'hFA, 1'b0);
    for (int i = 0; i < 20; i++) begin
      mk = mark_parity ? tb_mark_odd : tb_mark_even;
      mark_parity = ~mark_parity;
      send_word({mk, 16'($urandom)}, 1'b0);
    end
    send_word({tb_mark_even, 16'($urandom)}, 1'b1);

    // Random: sender 33 / receiver 46, long receiver hold-off first
    tx_idle_pct = 33;
    rx_idle_pct = 46;
    apply_config(4'd2, 8'h05, 8'hFA, 1'b0);
    rx_hold_req = 1'b1;
    send_frames(75);
    apply_config(4'd8, 8'h00, 8'hFF, 1'b0);
    send_frames(75);

    // Random: sender 46 / receiver 33
    tx_idle_pct = 46;
    rx_idle_pct = 33;
    apply_config(4'd1, 8'hFF, 8'h00, 1'b1);
    send_frames(75);
    apply_config(4'd5, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    send_frames(75);

    // Random: no idling apart from a long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(4'd7, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    rx_hold_req = 1'b1;
    send_frames(75);
    apply_config(4'd4, 8'hFF, 8'hFF, 1'b0);
    send_frames(75);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
